// ----- rtl/rtc_i2c_poll_sequencer_macros.svh -----
// ----------------------------------------------------------------------------
// rtc_i2c_poll_sequencer_macros
// Assertion macros used by the poll sequencer top level.
// ----------------------------------------------------------------------------
`ifndef RTC_I2C_POLL_SEQUENCER_MACROS_SVH
`define RTC_I2C_POLL_SEQUENCER_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define RPS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define RPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/rps_pkg.sv -----
// ----------------------------------------------------------------------------
// rps_pkg
// Types, bus command codes and image constants of the RTC poll sequencer.
// ----------------------------------------------------------------------------
package rps_pkg;

    localparam int REGISTER_COUNT_DEFAULT = 8;

    localparam logic [2:0] OP_NONE      = 3'd0;
    localparam logic [2:0] OP_START     = 3'd1;
    localparam logic [2:0] OP_SEND      = 3'd2;
    localparam logic [2:0] OP_READ_ACK  = 3'd3;
    localparam logic [2:0] OP_READ_NACK = 3'd4;
    localparam logic [2:0] OP_STOP      = 3'd5;

    localparam logic KIND_REQUEST = 1'b0;
    localparam logic KIND_DONE    = 1'b1;

    localparam logic [7:0] ADDR_WR    = 8'b1101_0000;
    localparam logic [7:0] ADDR_RD    = 8'b1101_0001;
    localparam logic [7:0] REG_INDEX0 = 8'h00;
    localparam logic [7:0] HALT_MASK  = 8'h80;
    localparam logic [7:0] CTRL_VALUE = 8'h10;
    localparam logic [7:0] CTRL_IDX   = 8'd7;
    localparam logic [7:0] MIN_IDX    = 8'd1;
    localparam logic [7:0] HOUR_IDX   = 8'd2;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] tx_const;
        logic       tx_mem;
        logic       taken;
        logic       changed;
        logic       rep_default;
        logic       fault;
        logic       two;
    } desc_t;

    typedef struct packed {
        logic [2:0] bus_op;
        logic [7:0] tx_byte;
        logic       request_taken;
        logic       time_changed;
        logic [7:0] hours_bcd;
        logic [7:0] minutes_bcd;
        logic       fault;
        logic       last;
    } res_t;

    typedef struct packed {
        logic       use_mem;
        logic [7:0] value;
    } src_t;

    function automatic logic [7:0] default_time(input logic [2:0] idx);
        logic [7:0] v;
        unique case (idx)
            3'd0:    v = 8'h00;
            3'd1:    v = 8'h39;
            3'd2:    v = 8'h13;
            3'd3:    v = 8'h03;
            3'd4:    v = 8'h28;
            3'd5:    v = 8'h10;
            default: v = 8'h13;
        endcase
        return v;
    endfunction

    function automatic src_t image_src(input logic [7:0] idx, input logic halt);
        src_t s;
        s.use_mem = 1'b0;
        s.value   = 8'h00;
        if (halt && (idx < CTRL_IDX))
        begin
            s.value = default_time(idx[2:0]);
        end
        else if (idx == CTRL_IDX)
        begin
            s.value = CTRL_VALUE;
        end
        else
        begin
            s.use_mem = 1'b1;
        end
        return s;
    endfunction

endpackage

// ----- rtl/rps_image_mem.sv -----
// ----------------------------------------------------------------------------
// rps_image_mem
// Register image store: one write port, two registered read ports, write
// data forwarded to a read of the same entry in the same cycle.
// ----------------------------------------------------------------------------
module rps_image_mem #(
    parameter int ADDR_W = 3
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rda_addr,
    input  logic [ADDR_W-1:0] rdb_addr,
    output logic [7:0]        rda_data,
    output logic [7:0]        rdb_data
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [7:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rda_data <= (wr_en && (wr_addr == rda_addr)) ? wr_data : mem[rda_addr];
            rdb_data <= (wr_en && (wr_addr == rdb_addr)) ? wr_data : mem[rdb_addr];
        end
    end

endmodule

// ----- rtl/rps_seq_ctrl.sv -----
// ----------------------------------------------------------------------------
// rps_seq_ctrl
// Command sequencer: steps through the read and write bursts, drives the
// image store and hands a result descriptor to the output stage per beat.
// ----------------------------------------------------------------------------
module rps_seq_ctrl #(
    parameter int REGISTER_COUNT = rps_pkg::REGISTER_COUNT_DEFAULT,
    parameter int IDX_W          = 3
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  logic               kind,
    input  logic [7:0]         rx_byte,
    output rps_pkg::desc_t     desc,
    output logic               mem_wr_en,
    output logic [IDX_W-1:0]   mem_wr_addr,
    output logic [7:0]         mem_wr_data,
    output logic [IDX_W-1:0]   mem_rda_addr,
    output logic [IDX_W-1:0]   mem_rdb_addr
);

    localparam int CNT_W = $clog2(REGISTER_COUNT + 1);
    localparam logic [CNT_W:0] RC_X = (CNT_W + 1)'(REGISTER_COUNT);
    localparam logic HAS_CTRL = (REGISTER_COUNT > 7);

    localparam logic [4:0] ST_IDLE      = 5'd0;
    localparam logic [4:0] ST_R_START   = 5'd1;
    localparam logic [4:0] ST_R_ADDR    = 5'd2;
    localparam logic [4:0] ST_R_INDEX   = 5'd3;
    localparam logic [4:0] ST_R_RESTART = 5'd4;
    localparam logic [4:0] ST_R_RADDR   = 5'd5;
    localparam logic [4:0] ST_R_READ    = 5'd6;
    localparam logic [4:0] ST_W_START   = 5'd7;
    localparam logic [4:0] ST_W_ADDR    = 5'd8;
    localparam logic [4:0] ST_W_INDEX   = 5'd9;
    localparam logic [4:0] ST_W_DATA    = 5'd10;

    logic             busy_reg,     busy_next;
    logic [4:0]       step_reg,     step_next;
    logic [CNT_W-1:0] cnt_reg,      cnt_next;
    logic             halt_reg,     halt_next;
    logic             ctrl_bad_reg, ctrl_bad_next;

    logic [CNT_W-1:0] cnt_inc;
    logic [CNT_W:0]   cnt_inc2;
    logic [7:0]       cnt8;
    logic             halt_now;
    logic             ctrl_bad_now;
    logic             fix;
    rps_pkg::src_t    img_cnt;
    rps_pkg::src_t    img_zero;

    assign cnt_inc      = cnt_reg + CNT_W'(1);
    assign cnt_inc2     = {1'b0, cnt_inc} + (CNT_W + 1)'(1);
    assign cnt8         = 8'(cnt_reg);
    assign halt_now     = (cnt_reg == '0) ? ((rx_byte & rps_pkg::HALT_MASK) != 8'h00)
                                          : halt_reg;
    assign ctrl_bad_now = (cnt8 == rps_pkg::CTRL_IDX) ? (rx_byte != rps_pkg::CTRL_VALUE)
                                                      : ctrl_bad_reg;
    assign fix          = halt_now || (HAS_CTRL && ctrl_bad_now);
    assign img_cnt      = rps_pkg::image_src(cnt8, halt_reg);
    assign img_zero     = rps_pkg::image_src(8'd0, halt_reg);

    always_comb
    begin
        busy_next     = busy_reg;
        step_next     = step_reg;
        cnt_next      = cnt_reg;
        halt_next     = halt_reg;
        ctrl_bad_next = ctrl_bad_reg;
        desc          = '0;
        desc.op       = rps_pkg::OP_NONE;
        mem_wr_en     = 1'b0;
        mem_wr_addr   = cnt_reg[IDX_W-1:0];
        mem_wr_data   = rx_byte;
        mem_rda_addr  = IDX_W'(rps_pkg::MIN_IDX);
        mem_rdb_addr  = IDX_W'(rps_pkg::HOUR_IDX);

        if (!fire)
        begin
            desc.op = rps_pkg::OP_NONE;
        end
        else if (kind == rps_pkg::KIND_REQUEST)
        begin
            if (!busy_reg)
            begin
                busy_next  = 1'b1;
                step_next  = ST_R_START;
                cnt_next   = '0;
                desc.op    = rps_pkg::OP_START;
                desc.taken = 1'b1;
            end
        end
        else if (!busy_reg)
        begin
            desc.fault = 1'b1;
        end
        else
        begin
            unique case (step_reg)
                ST_R_START:
                begin
                    step_next     = ST_R_ADDR;
                    desc.op       = rps_pkg::OP_SEND;
                    desc.tx_const = rps_pkg::ADDR_WR;
                end
                ST_R_ADDR:
                begin
                    step_next     = ST_R_INDEX;
                    desc.op       = rps_pkg::OP_SEND;
                    desc.tx_const = rps_pkg::REG_INDEX0;
                end
                ST_R_INDEX:
                begin
                    step_next = ST_R_RESTART;
                    desc.op   = rps_pkg::OP_START;
                end
                ST_R_RESTART:
                begin
                    step_next     = ST_R_RADDR;
                    desc.op       = rps_pkg::OP_SEND;
                    desc.tx_const = rps_pkg::ADDR_RD;
                end
                ST_R_RADDR:
                begin
                    step_next = ST_R_READ;
                    cnt_next  = '0;
                    desc.op   = (REGISTER_COUNT > 1) ? rps_pkg::OP_READ_ACK
                                                     : rps_pkg::OP_READ_NACK;
                end
                ST_R_READ:
                begin
                    mem_wr_en     = 1'b1;
                    halt_next     = halt_now;
                    ctrl_bad_next = ctrl_bad_now;
                    if ({1'b0, cnt_inc} < RC_X)
                    begin
                        cnt_next = cnt_inc;
                        desc.op  = (cnt_inc2 < RC_X) ? rps_pkg::OP_READ_ACK
                                                     : rps_pkg::OP_READ_NACK;
                    end
                    else
                    begin
                        cnt_next         = '0;
                        desc.op          = rps_pkg::OP_STOP;
                        desc.changed     = 1'b1;
                        desc.rep_default = halt_now;
                        if (fix)
                        begin
                            desc.two  = 1'b1;
                            step_next = ST_W_START;
                        end
                        else
                        begin
                            busy_next = 1'b0;
                            step_next = ST_IDLE;
                        end
                    end
                end
                ST_W_START:
                begin
                    step_next     = ST_W_ADDR;
                    desc.op       = rps_pkg::OP_SEND;
                    desc.tx_const = rps_pkg::ADDR_WR;
                end
                ST_W_ADDR:
                begin
                    step_next     = ST_W_INDEX;
                    desc.op       = rps_pkg::OP_SEND;
                    desc.tx_const = rps_pkg::REG_INDEX0;
                end
                ST_W_INDEX:
                begin
                    step_next     = ST_W_DATA;
                    cnt_next      = CNT_W'(1);
                    desc.op       = rps_pkg::OP_SEND;
                    desc.tx_const = img_zero.value;
                    desc.tx_mem   = img_zero.use_mem;
                    mem_rda_addr  = '0;
                end
                ST_W_DATA:
                begin
                    if ({1'b0, cnt_reg} < RC_X)
                    begin
                        cnt_next      = cnt_inc;
                        desc.op       = rps_pkg::OP_SEND;
                        desc.tx_const = img_cnt.value;
                        desc.tx_mem   = img_cnt.use_mem;
                        mem_rda_addr  = cnt_reg[IDX_W-1:0];
                    end
                    else
                    begin
                        busy_next = 1'b0;
                        step_next = ST_IDLE;
                        cnt_next  = '0;
                        desc.op   = rps_pkg::OP_STOP;
                    end
                end
                default:
                begin
                    desc.op = rps_pkg::OP_NONE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            step_reg     <= ST_IDLE;
            cnt_reg      <= '0;
            halt_reg     <= 1'b0;
            ctrl_bad_reg <= 1'b0;
        end
        else
        begin
            busy_reg     <= busy_next;
            step_reg     <= step_next;
            cnt_reg      <= cnt_next;
            halt_reg     <= halt_next;
            ctrl_bad_reg <= ctrl_bad_next;
        end
    end

endmodule

// ----- rtl/rps_out_stage.sv -----
// ----------------------------------------------------------------------------
// rps_out_stage
// Output stage: holds one descriptor, merges image read data and issues up
// to two result beats through a registered master port.
// ----------------------------------------------------------------------------
module rps_out_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           load,
    input  rps_pkg::desc_t desc_in,
    input  logic [7:0]     rda_data,
    input  logic [7:0]     rdb_data,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    output rps_pkg::res_t  out_res
);

    rps_pkg::desc_t desc_reg,       desc_next;
    logic           desc_valid_reg, desc_valid_next;
    logic           phase_reg,      phase_next;
    logic           out_valid_reg,  out_valid_next;
    rps_pkg::res_t  res_reg,        res_next;

    logic           out_free;
    logic           emit;
    logic           desc_done;
    rps_pkg::res_t  first_res;
    rps_pkg::res_t  second_res;

    assign out_free  = !out_valid_reg || out_ready;
    assign emit      = desc_valid_reg && out_free;
    assign desc_done = emit && (!desc_reg.two || phase_reg);
    assign in_ready  = !desc_valid_reg || desc_done;

    always_comb
    begin
        first_res               = '0;
        first_res.bus_op        = desc_reg.op;
        first_res.tx_byte       = desc_reg.tx_mem ? rda_data : desc_reg.tx_const;
        first_res.request_taken = desc_reg.taken;
        first_res.time_changed  = desc_reg.changed;
        first_res.fault         = desc_reg.fault;
        first_res.last          = !desc_reg.two;
        if (desc_reg.changed)
        begin
            first_res.hours_bcd   = desc_reg.rep_default
                                    ? rps_pkg::default_time(rps_pkg::HOUR_IDX[2:0])
                                    : rdb_data;
            first_res.minutes_bcd = desc_reg.rep_default
                                    ? rps_pkg::default_time(rps_pkg::MIN_IDX[2:0])
                                    : rda_data;
        end

        second_res        = '0;
        second_res.bus_op = rps_pkg::OP_START;
        second_res.last   = 1'b1;
    end

    always_comb
    begin
        desc_next       = desc_reg;
        desc_valid_next = desc_valid_reg;
        phase_next      = phase_reg;
        out_valid_next  = out_valid_reg;
        res_next        = res_reg;

        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
            res_next       = phase_reg ? second_res : first_res;
            phase_next     = !phase_reg && desc_reg.two;
        end
        if (desc_done)
        begin
            desc_valid_next = 1'b0;
        end
        if (load)
        begin
            desc_next       = desc_in;
            desc_valid_next = 1'b1;
            phase_next      = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            desc_valid_reg <= 1'b0;
            phase_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            desc_valid_reg <= desc_valid_next;
            phase_reg      <= phase_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        desc_reg <= desc_next;
        res_reg  <= res_next;
    end

    assign out_valid = out_valid_reg;
    assign out_res   = res_reg;

endmodule

// ----- rtl/rtc_i2c_poll_sequencer.sv -----
// ----------------------------------------------------------------------------
// rtc_i2c_poll_sequencer
// Polls an I2C real-time clock through a byte-level bus engine.
// Slave beats: tuser 0 is a poll request, tuser 1 reports that the engine
// finished its last command, with the read byte in tdata.
// Master beats carry one bus command each, plus the refused-request, fault
// and time-changed reports; tlast marks the final beat for a slave beat.
// A slave beat yields one master beat, or two at the end of a read burst
// that needs a write-back; its descriptor is registered in the slot, then
// its beat in the output register. Throughput: one slave beat per cycle
// unless the master port stalls; a two-beat answer holds s_tready low until
// its second beat; the single descriptor slot sets this. The register
// image sits in a registered-read store, read the cycle a beat is taken
// and forwarded when written in the same cycle. Reset clears the sequencer
// to idle with no beat pending; the image store is not cleared. A stalled
// master port holds its beat, fills the slot and then drops slave tready.
// ----------------------------------------------------------------------------
`include "rtc_i2c_poll_sequencer_macros.svh"

module rtc_i2c_poll_sequencer #(
    parameter int REGISTER_COUNT = rps_pkg::REGISTER_COUNT_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // rx_byte[7:0]
    input  logic        s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // bus_op, tx_byte, request_taken, time_changed,
                                   // hours_bcd, minutes_bcd, fault, zero pad
    output logic        m_tlast
);

    localparam int IDX_W = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;

    logic             fire;
    rps_pkg::desc_t   desc;
    logic             mem_wr_en;
    logic [IDX_W-1:0] mem_wr_addr;
    logic [7:0]       mem_wr_data;
    logic [IDX_W-1:0] mem_rda_addr;
    logic [IDX_W-1:0] mem_rdb_addr;
    logic [7:0]       rda_data;
    logic [7:0]       rdb_data;
    rps_pkg::res_t    m_res;

    assign fire = s_tvalid && s_tready;

    rps_seq_ctrl #(
        .REGISTER_COUNT (REGISTER_COUNT),
        .IDX_W          (IDX_W)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (fire),
        .kind         (s_tuser),
        .rx_byte      (s_tdata),
        .desc         (desc),
        .mem_wr_en    (mem_wr_en),
        .mem_wr_addr  (mem_wr_addr),
        .mem_wr_data  (mem_wr_data),
        .mem_rda_addr (mem_rda_addr),
        .mem_rdb_addr (mem_rdb_addr)
    );

    rps_image_mem #(
        .ADDR_W (IDX_W)
    ) u_mem (
        .clk      (clk),
        .wr_en    (mem_wr_en),
        .wr_addr  (mem_wr_addr),
        .wr_data  (mem_wr_data),
        .rd_en    (fire),
        .rda_addr (mem_rda_addr),
        .rdb_addr (mem_rdb_addr),
        .rda_data (rda_data),
        .rdb_data (rdb_data)
    );

    rps_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire),
        .desc_in   (desc),
        .rda_data  (rda_data),
        .rdb_data  (rdb_data),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (m_res)
    );

    assign m_tdata = {2'b00, m_res.fault, m_res.minutes_bcd, m_res.hours_bcd,
                      m_res.time_changed, m_res.request_taken, m_res.tx_byte,
                      m_res.bus_op};
    assign m_tlast = m_res.last;

    `RPS_ASSERT_IMP(a_changed_on_stop, m_tvalid && m_res.time_changed, m_res.bus_op == rps_pkg::OP_STOP, "time change reported off a stop beat")
    `RPS_ASSERT_IMP(a_fault_alone, m_tvalid && m_res.fault, m_tlast && (m_res.bus_op == rps_pkg::OP_NONE), "fault beat carries a command")
    `RPS_ASSERT_IMP(a_taken_is_start, m_tvalid && m_res.request_taken, m_tlast && (m_res.bus_op == rps_pkg::OP_START), "taken request without a single start beat")
    `RPS_ASSERT_NEXT(a_accept_fills_output, fire && !m_tvalid, ##1 m_tvalid, "accepted beat not presented within two cycles")

endmodule
